FILE: hdl/mrr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// mrr_pkg
// Shared types, codes and reset values of the Modbus RTU response receiver.
// ============================================================================
package mrr_pkg;

    // Default frame store depth in bytes.
    localparam int BUFFER_DEPTH_DEF = 32;

    // Index width for walking the frame: a declared length of 255 plus the
    // three header bytes needs nine bits.
    localparam int IDX_W = 9;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS = 1'd1;

    // Request types.
    localparam logic [1:0] REQ_BYTE = 2'd0;
    localparam logic [1:0] REQ_TICK = 2'd1;
    localparam logic [1:0] REQ_CMD  = 2'd2;

    // Result status codes.
    localparam logic [1:0] STS_NONE    = 2'd0;
    localparam logic [1:0] STS_UPDATED = 2'd1;
    localparam logic [1:0] STS_CRC_BAD = 2'd2;
    localparam logic [1:0] STS_IGNORED = 2'd3;

    // Modbus function codes and pending command codes.
    localparam logic [7:0] FC_READ_HOLDING = 8'h03;
    localparam logic [7:0] FC_READ_INPUT   = 8'h04;
    localparam logic [7:0] CMD_READ_PV     = 8'h01;
    localparam logic [7:0] CMD_READ_SP     = 8'h02;

    // Reset values.
    localparam logic [15:0] TIMEOUT_RST = 16'd10;
    localparam logic [7:0]  ADDRESS_RST = 8'd1;
    localparam logic [15:0] IDLE_RST    = 16'd100;
    localparam logic [15:0] SP_RST      = 16'hFF6A;
    localparam logic [15:0] PV_RST      = 16'h0000;

    // Outcome of one frame evaluation.
    typedef struct packed {
        logic        done;
        logic [1:0]  status;
        logic        load_sp;
        logic        load_pv;
        logic [15:0] value;
    } eval_result_t;

endpackage
`default_nettype wire

FILE: hdl/modbus_rtu_response_receiver.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// modbus_rtu_response_receiver
// Receive side of a Modbus RTU master: frame assembly, end-of-frame timeout,
// CRC-16 check and update of the process value and set value registers.
// ============================================================================
// Usage:
// Each request on the s_ channel is a received byte, a timer tick or an
// issued command. Every request yields exactly one result on the m_ channel,
// carrying frame_end, status and the current process and set values.
// Configuration (timeout in ticks, station address) is written through
// cfg_we/cfg_index/cfg_wdata; the user must write it only while the block is
// idle, which the block itself does not enforce. A byte, command or
// non-closing tick passes through the result and output registers to the
// m_ channel; no new request is taken while the result register holds one.
// A tick that closes a frame walks the stored bytes one per cycle through the
// single store read port and the byte-wide CRC unit; a frame whose declared
// byte count plus 5 exceeds BUFFER_DEPTH is rejected at the header.
// A result register plus an output register decouple the two sides: one
// request is still taken while a result waits, after which s_ready stays low
// until m_ready drains the output.
// Reset (synchronous, active low) empties the frame, sets the idle counter to
// 100, the timeout to 10, the address to 1, the process value to 0 and the
// set value to -150.
// ============================================================================
module modbus_rtu_response_receiver #(
    parameter int BUFFER_DEPTH = mrr_pkg::BUFFER_DEPTH_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Request channel
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [1:0]                     s_req_type,
    input  wire logic [7:0]                     s_rx_byte,
    input  wire logic [7:0]                     s_command_code,
    // Result channel
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic                                m_frame_end,
    output logic [1:0]                          m_status,
    output logic signed [15:0]                  m_process_value,
    output logic signed [15:0]                  m_set_value,
    // Configuration port
    input  wire logic                           cfg_we,
    input  wire logic [mrr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mrr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import mrr_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EVAL = 1'b1;

    logic        state_reg, state_next;
    logic [15:0] timeout_reg;
    logic [7:0]  address_reg;
    logic [15:0] idle_reg, idle_next;
    logic [7:0]  pending_reg, pending_next;
    logic [15:0] pv_reg, pv_next;
    logic [15:0] sp_reg, sp_next;

    // Result stage, then output stage.
    logic        res_valid_reg, res_valid_next;
    logic        res_fe_reg, res_fe_next;
    logic [1:0]  res_status_reg, res_status_next;
    logic        out_valid_reg;
    logic        out_fe_reg;
    logic [1:0]  out_status_reg;
    logic [15:0] out_pv_reg;
    logic [15:0] out_sp_reg;
    logic        out_load;

    logic         accept;
    logic         byte_wr;
    logic         frame_clear;
    logic         eval_start;
    logic [15:0]  idle_inc;
    logic         not_empty;
    logic         rd_en;
    logic [IDX_W-1:0] rd_idx;
    logic         rd_valid;
    logic [7:0]   rd_data;
    eval_result_t chk_res;

    mrr_frame_store #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (byte_wr),
        .wr_data   (s_rx_byte),
        .clear     (frame_clear),
        .rd_en     (rd_en),
        .rd_idx    (rd_idx),
        .rd_valid  (rd_valid),
        .rd_data   (rd_data),
        .not_empty (not_empty)
    );

    mrr_frame_check #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .start           (eval_start),
        .slave_address   (address_reg),
        .pending_command (pending_reg),
        .rd_valid        (rd_valid),
        .rd_data         (rd_data),
        .rd_en           (rd_en),
        .rd_idx          (rd_idx),
        .result          (chk_res)
    );

    assign s_ready  = (state_reg == S_IDLE) && !res_valid_reg;
    assign accept   = s_valid && s_ready;
    assign out_load = res_valid_reg && (!out_valid_reg || m_ready);
    assign idle_inc = (idle_reg < timeout_reg) ? idle_reg + 16'd1 : idle_reg;

    // Request handling and frame close.
    always_comb begin
        state_next      = state_reg;
        idle_next       = idle_reg;
        pending_next    = pending_reg;
        pv_next         = pv_reg;
        sp_next         = sp_reg;
        res_valid_next  = res_valid_reg;
        res_fe_next     = res_fe_reg;
        res_status_next = res_status_reg;
        byte_wr         = 1'b0;
        frame_clear     = 1'b0;
        eval_start      = 1'b0;

        if (out_load) begin
            res_valid_next = 1'b0;
        end

        if (accept) begin
            res_valid_next  = 1'b1;
            res_fe_next     = 1'b0;
            res_status_next = STS_NONE;
            case (s_req_type)
                REQ_BYTE: begin
                    idle_next = '0;
                    byte_wr   = 1'b1;
                end
                REQ_TICK: begin
                    if (idle_inc == timeout_reg && not_empty) begin
                        idle_next      = '0;
                        eval_start     = 1'b1;
                        state_next     = S_EVAL;
                        res_valid_next = 1'b0;
                    end else begin
                        idle_next = idle_inc;
                    end
                end
                REQ_CMD: begin
                    pending_next = s_command_code;
                end
                default: begin
                end
            endcase
        end

        if (chk_res.done) begin
            if (chk_res.load_sp) begin
                sp_next = chk_res.value;
            end
            if (chk_res.load_pv) begin
                pv_next = chk_res.value;
            end
            frame_clear     = 1'b1;
            pending_next    = '0;
            state_next      = S_IDLE;
            res_valid_next  = 1'b1;
            res_fe_next     = 1'b1;
            res_status_next = chk_res.status;
        end
    end

    // Control and architectural registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            timeout_reg    <= TIMEOUT_RST;
            address_reg    <= ADDRESS_RST;
            idle_reg       <= IDLE_RST;
            pending_reg    <= '0;
            pv_reg         <= PV_RST;
            sp_reg         <= SP_RST;
            res_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            idle_reg      <= idle_next;
            pending_reg   <= pending_next;
            pv_reg        <= pv_next;
            sp_reg        <= sp_next;
            res_valid_reg <= res_valid_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                case (cfg_index)
                    CFG_TIMEOUT: timeout_reg <= cfg_wdata;
                    CFG_ADDRESS: address_reg <= cfg_wdata[7:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Result payload; the value registers are sampled when the result moves to the output stage.
    always_ff @(posedge aclk) begin
        res_fe_reg     <= res_fe_next;
        res_status_reg <= res_status_next;
        if (out_load) begin
            out_fe_reg     <= res_fe_reg;
            out_status_reg <= res_status_reg;
            out_pv_reg     <= pv_reg;
            out_sp_reg     <= sp_reg;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_frame_end     = out_fe_reg;
    assign m_status        = out_status_reg;
    assign m_process_value = out_pv_reg;
    assign m_set_value     = out_sp_reg;

    // A verdict only arrives while a frame is being evaluated.
    assert property (@(posedge aclk) disable iff (!aresetn)
        chk_res.done |-> state_reg == S_EVAL)
        else $error("frame verdict outside evaluation");

    // No request result is pending during an evaluation.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_EVAL |-> !res_valid_reg)
        else $error("result pending during evaluation");

    // A status other than none only accompanies a closed frame.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_frame_end) |-> m_status == STS_NONE)
        else $error("status without frame end");

    // A received byte restarts the idle counter.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_req_type == REQ_BYTE) |=> idle_reg == 16'd0)
        else $error("idle counter not restarted by byte");

endmodule
`default_nettype wire

FILE: hdl/mrr_frame_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// mrr_frame_store
// Byte store of the current frame with a fill count. Entries at or beyond the
// fill count read as zero, so clearing the frame only resets the count.
// ============================================================================
module mrr_frame_store #(
    parameter int BUFFER_DEPTH = mrr_pkg::BUFFER_DEPTH_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      wr_en,
    input  wire logic [7:0]                wr_data,
    input  wire logic                      clear,
    input  wire logic                      rd_en,
    input  wire logic [mrr_pkg::IDX_W-1:0] rd_idx,
    output logic                           rd_valid,
    output logic [7:0]                     rd_data,
    output logic                           not_empty
);
    import mrr_pkg::*;

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int CW = $clog2(BUFFER_DEPTH + 1);

    logic [7:0]    mem [BUFFER_DEPTH];
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [7:0]    data_reg;
    logic          hit_reg;
    logic          valid_reg;
    logic          room;

    assign room = count_reg < CW'(BUFFER_DEPTH);

    // Fill count: a byte that finds the store full is dropped.
    always_comb begin
        count_next = count_reg;
        if (clear) begin
            count_next = '0;
        end else if (wr_en && room) begin
            count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            valid_reg <= rd_en;
        end
    end

    // Memory write at the fill position.
    always_ff @(posedge aclk) begin
        if (wr_en && room) begin
            mem[count_reg[AW-1:0]] <= wr_data;
        end
    end

    // Registered read; positions not filled in this frame read as zero.
    always_ff @(posedge aclk) begin
        data_reg <= mem[rd_idx[AW-1:0]];
        hit_reg  <= rd_idx < IDX_W'(count_reg);
    end

    assign rd_valid  = valid_reg;
    assign rd_data   = hit_reg ? data_reg : 8'h00;
    assign not_empty = count_reg != '0;

endmodule
`default_nettype wire

FILE: hdl/mrr_crc16.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// mrr_crc16
// CRC-16/Modbus accumulator, one byte per cycle while en is high (reflected poly 0xA001).
// ============================================================================
module mrr_crc16 (
    input  wire logic       aclk,
    input  wire logic       init,
    input  wire logic       en,
    input  wire logic [7:0] data,
    output logic [15:0]     crc
);
    localparam logic [15:0] POLY     = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    logic [15:0] crc_reg;
    logic [15:0] crc_next;

    // Eight shift steps of the reflected CRC for one byte.
    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] d);
        logic [15:0] r;
        r = c ^ {8'h00, d};
        for (int b = 0; b < 8; b++) begin
            r = r[0] ? ((r >> 1) ^ POLY) : (r >> 1);
        end
        return r;
    endfunction

    always_comb begin
        crc_next = crc_reg;
        if (init) begin
            crc_next = CRC_INIT;
        end else if (en) begin
            crc_next = crc_byte(crc_reg, data);
        end
    end

    always_ff @(posedge aclk) begin
        crc_reg <= crc_next;
    end

    assign crc = crc_reg;

endmodule
`default_nettype wire

FILE: hdl/mrr_frame_check.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// mrr_frame_check
// Walks a closed frame byte by byte through the store read port, checks the
// header, length and CRC, and decides which value register to load.
// ============================================================================
module mrr_frame_check #(
    parameter int BUFFER_DEPTH = mrr_pkg::BUFFER_DEPTH_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic [7:0]                slave_address,
    input  wire logic [7:0]                pending_command,
    input  wire logic                      rd_valid,
    input  wire logic [7:0]                rd_data,
    output logic                           rd_en,
    output logic [mrr_pkg::IDX_W-1:0]      rd_idx,
    output mrr_pkg::eval_result_t          result
);
    import mrr_pkg::*;

    localparam int LEN_W = 10;
    localparam logic [IDX_W-1:0] POS_ADDR  = IDX_W'(0);
    localparam logic [IDX_W-1:0] POS_FUNC  = IDX_W'(1);
    localparam logic [IDX_W-1:0] POS_COUNT = IDX_W'(2);
    localparam logic [IDX_W-1:0] POS_VHI   = IDX_W'(3);
    localparam logic [IDX_W-1:0] POS_VLO   = IDX_W'(4);
    localparam logic [IDX_W-1:0] HDR_LEN   = IDX_W'(3);

    logic             running_reg, running_next;
    logic [IDX_W-1:0] iss_reg;
    logic [IDX_W-1:0] ret_reg;
    logic             addr_ok_reg;
    logic [7:0]       fc_reg;
    logic [IDX_W-1:0] n_reg;
    logic [7:0]       val_hi_reg;
    logic [7:0]       val_lo_reg;
    logic [7:0]       crc_lo_reg;
    eval_result_t     result_reg, result_next;

    logic        step;
    logic        fc_ok;
    logic        too_long;
    logic        hdr_fail;
    logic        at_end;
    logic        crc_en;
    logic        crc_ok;
    logic [15:0] crc;
    logic [15:0] value;

    mrr_crc16 u_crc (
        .aclk (aclk),
        .init (start),
        .en   (crc_en),
        .data (rd_data),
        .crc  (crc)
    );

    // Byte position decode.
    always_comb begin
        step     = running_reg && rd_valid;
        fc_ok    = (fc_reg == FC_READ_HOLDING) || (fc_reg == FC_READ_INPUT);
        too_long = (LEN_W'(rd_data) + LEN_W'(5)) > LEN_W'(BUFFER_DEPTH);
        hdr_fail = step && (ret_reg == POS_COUNT) && (!addr_ok_reg || !fc_ok || too_long);
        at_end   = step && (ret_reg > POS_COUNT) && (ret_reg == n_reg + IDX_W'(1));
        crc_en   = step && ((ret_reg < HDR_LEN) || (ret_reg < n_reg));
        crc_ok   = {rd_data, crc_lo_reg} == crc;
        value    = {val_hi_reg, (ret_reg == POS_VLO) ? rd_data : val_lo_reg};
    end

    // Verdict of the frame.
    always_comb begin
        result_next         = '0;
        result_next.value   = value;
        result_next.status  = STS_NONE;
        if (hdr_fail) begin
            result_next.done   = 1'b1;
            result_next.status = STS_IGNORED;
        end else if (at_end) begin
            result_next.done = 1'b1;
            if (!crc_ok) begin
                result_next.status = STS_CRC_BAD;
            end else if (fc_reg == FC_READ_HOLDING && pending_command == CMD_READ_SP) begin
                result_next.status  = STS_UPDATED;
                result_next.load_sp = 1'b1;
            end else if (fc_reg == FC_READ_INPUT && pending_command == CMD_READ_PV) begin
                result_next.status  = STS_UPDATED;
                result_next.load_pv = 1'b1;
            end else begin
                result_next.status = STS_IGNORED;
            end
        end
    end

    always_comb begin
        running_next = running_reg;
        if (start) begin
            running_next = 1'b1;
        end else if (hdr_fail || at_end) begin
            running_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg <= 1'b0;
            result_reg  <= '0;
        end else begin
            running_reg <= running_next;
            result_reg  <= result_next;
        end
    end

    // Read issue and return counters, captured header and trailer bytes.
    always_ff @(posedge aclk) begin
        if (start) begin
            iss_reg <= '0;
            ret_reg <= '0;
        end else begin
            if (running_reg) begin
                iss_reg <= iss_reg + IDX_W'(1);
            end
            if (step) begin
                ret_reg <= ret_reg + IDX_W'(1);
            end
        end
        if (step) begin
            if (ret_reg == POS_ADDR) begin
                addr_ok_reg <= rd_data == slave_address;
            end
            if (ret_reg == POS_FUNC) begin
                fc_reg <= rd_data;
            end
            if (ret_reg == POS_COUNT) begin
                n_reg <= IDX_W'(rd_data) + HDR_LEN;
            end
            if (ret_reg == POS_VHI) begin
                val_hi_reg <= rd_data;
            end
            if (ret_reg == POS_VLO) begin
                val_lo_reg <= rd_data;
            end
            if (ret_reg == n_reg) begin
                crc_lo_reg <= rd_data;
            end
        end
    end

    assign rd_en  = running_reg;
    assign rd_idx = iss_reg;
    assign result = result_reg;

endmodule
`default_nettype wire
